FILE: src/hrlp_pkg.sv
package hrlp_pkg;

    // Output queue geometry
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Character codes
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_QMARK   = 8'h3F;
    localparam logic [7:0] CH_G       = 8'h47;
    localparam logic [7:0] CH_H       = 8'h48;
    localparam logic [7:0] CH_E       = 8'h45;
    localparam logic [7:0] CH_T       = 8'h54;
    localparam logic [7:0] CH_A       = 8'h41;
    localparam logic [7:0] CH_D       = 8'h44;

    // Method match positions of a complete GET and HEAD
    localparam logic [2:0] POS_NONE     = 3'd0;
    localparam logic [2:0] POS_G        = 3'd1;
    localparam logic [2:0] POS_GET_DONE = 3'd3;
    localparam logic [2:0] POS_H        = 3'd4;
    localparam logic [2:0] POS_HEAD_DONE = 3'd7;

    // Token count, saturating
    localparam logic [2:0] TOK_METHOD = 3'd1;
    localparam logic [2:0] TOK_URI    = 3'd2;
    localparam logic [2:0] TOK_ALL    = 3'd3;
    localparam logic [2:0] TOK_SAT    = 3'd4;

    // Result codes
    localparam logic       KIND_URI    = 1'b0;
    localparam logic       KIND_REPORT = 1'b1;
    localparam logic [1:0] METH_GET    = 2'd0;
    localparam logic [1:0] METH_HEAD   = 2'd1;
    localparam logic [1:0] METH_OTHER  = 2'd2;
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_COUNT  = 2'd1;
    localparam logic [1:0] STAT_ESCAPE = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LINE = 2'd1,
        PH_DONE = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        HEX_NONE = 2'd0,
        HEX_HI   = 2'd1,
        HEX_LO   = 2'd2
    } hex_state_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] uri;
        logic [1:0] method;
        logic [1:0] status;
        logic       last;
    } result_t;

    // Results of one byte: count and up to two entries in order
    typedef struct packed {
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } push_t;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic hex_t hex_digit(input logic [7:0] b);
        hex_t h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (b >= 8'h30 && b <= 8'h39)
            h.val = 4'(b - 8'h30);
        else if (b >= 8'h61 && b <= 8'h66)
            h.val = 4'(b - 8'h61 + 8'd10);
        else if (b >= 8'h41 && b <= 8'h46)
            h.val = 4'(b - 8'h41 + 8'd10);
        else
            h.ok = 1'b0;
        return h;
    endfunction

    // Character expected after a partial method match; zero where none
    function automatic logic [7:0] next_method_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd1:    c = CH_E;
            3'd2:    c = CH_T;
            3'd4:    c = CH_E;
            3'd5:    c = CH_A;
            3'd6:    c = CH_D;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

FILE: src/hrlp_core.sv
module hrlp_core
    import hrlp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic [7:0] item_byte,
    input  logic       item_start,
    input  logic       item_final,
    output push_t      push
);

    phase_t     phase_reg, phase_next;
    logic [2:0] tok_reg, tok_next;
    logic       between_reg, between_next;
    logic [2:0] pos_reg, pos_next;
    logic       mismatch_reg, mismatch_next;
    logic       query_reg, query_next;
    hex_state_t hexp_reg, hexp_next;
    logic [3:0] hexhi_reg, hexhi_next;
    logic       escerr_reg, escerr_next;

    // Hold parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            tok_reg      <= 3'd0;
            between_reg  <= 1'b1;
            pos_reg      <= POS_NONE;
            mismatch_reg <= 1'b0;
            query_reg    <= 1'b0;
            hexp_reg     <= HEX_NONE;
            hexhi_reg    <= 4'd0;
            escerr_reg   <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            tok_reg      <= tok_next;
            between_reg  <= between_next;
            pos_reg      <= pos_next;
            mismatch_reg <= mismatch_next;
            query_reg    <= query_next;
            hexp_reg     <= hexp_next;
            hexhi_reg    <= hexhi_next;
            escerr_reg   <= escerr_next;
        end
    end

    // Decode one byte and build its results
    always_comb
    begin
        logic       emit;
        logic       report;
        logic [7:0] ob;
        logic [1:0] meth;
        logic [1:0] stat;
        logic [7:0] want;
        hex_t       hv;
        result_t    ru;
        result_t    rr;

        phase_next    = phase_reg;
        tok_next      = tok_reg;
        between_next  = between_reg;
        pos_next      = pos_reg;
        mismatch_next = mismatch_reg;
        query_next    = query_reg;
        hexp_next     = hexp_reg;
        hexhi_next    = hexhi_reg;
        escerr_next   = escerr_reg;
        emit   = 1'b0;
        report = 1'b0;
        ob     = 8'h00;
        meth   = METH_OTHER;
        stat   = STAT_OK;
        want   = next_method_char(pos_reg);
        hv     = hex_digit(item_byte);

        if (item_valid)
        begin
            // Start a fresh line
            if (item_start)
            begin
                phase_next    = PH_LINE;
                tok_next      = 3'd0;
                between_next  = 1'b1;
                pos_next      = POS_NONE;
                mismatch_next = 1'b0;
                query_next    = 1'b0;
                hexp_next     = HEX_NONE;
                hexhi_next    = 4'd0;
                escerr_next   = 1'b0;
            end

            if (phase_next == PH_LINE)
            begin
                if (item_byte != CH_CR)
                begin
                    if (is_ws(item_byte))
                    begin
                        // Close the current token
                        if (!between_next)
                        begin
                            if (hexp_next != HEX_NONE)
                            begin
                                escerr_next = 1'b1;
                                hexp_next   = HEX_NONE;
                            end
                            between_next = 1'b1;
                        end
                    end
                    else
                    begin
                        if (between_next)
                        begin
                            if (tok_next < TOK_SAT)
                                tok_next = tok_next + 3'd1;
                            between_next = 1'b0;
                        end

                        if (tok_next == TOK_METHOD)
                        begin
                            // Advance the method match
                            if (!mismatch_next)
                            begin
                                if (pos_next == POS_NONE)
                                begin
                                    if (item_byte == CH_G)
                                        pos_next = POS_G;
                                    else if (item_byte == CH_H)
                                        pos_next = POS_H;
                                    else
                                        mismatch_next = 1'b1;
                                end
                                else if (want != 8'h00 && item_byte == want)
                                    pos_next = pos_next + 3'd1;
                                else
                                    mismatch_next = 1'b1;
                            end
                        end
                        else if (tok_next == TOK_URI && !query_next && !escerr_next)
                        begin
                            // Decode the URI
                            if (hexp_next != HEX_NONE)
                            begin
                                if (!hv.ok)
                                begin
                                    escerr_next = 1'b1;
                                    hexp_next   = HEX_NONE;
                                end
                                else if (hexp_next == HEX_HI)
                                begin
                                    hexhi_next = hv.val;
                                    hexp_next  = HEX_LO;
                                end
                                else
                                begin
                                    hexp_next = HEX_NONE;
                                    emit      = 1'b1;
                                    ob        = {hexhi_next, hv.val};
                                end
                            end
                            else if (item_byte == CH_PERCENT)
                                hexp_next = HEX_HI;
                            else if (item_byte == CH_QMARK)
                                query_next = 1'b1;
                            else
                            begin
                                emit = 1'b1;
                                ob   = (item_byte == CH_PLUS) ? CH_SPACE : item_byte;
                            end
                        end
                    end
                end

                // End of line: close the token and report
                if (item_byte == CH_CR || item_final)
                begin
                    if (hexp_next != HEX_NONE)
                    begin
                        escerr_next = 1'b1;
                        hexp_next   = HEX_NONE;
                    end
                    between_next = 1'b1;
                    if (!mismatch_next && pos_next == POS_GET_DONE)
                        meth = METH_GET;
                    else if (!mismatch_next && pos_next == POS_HEAD_DONE)
                        meth = METH_HEAD;
                    if (tok_next != TOK_ALL)
                        stat = STAT_COUNT;
                    else if (escerr_next)
                        stat = STAT_ESCAPE;
                    report     = 1'b1;
                    phase_next = PH_DONE;
                end
            end
        end

        ru.kind   = KIND_URI;
        ru.uri    = ob;
        ru.method = 2'd0;
        ru.status = 2'd0;
        ru.last   = !report;
        rr.kind   = KIND_REPORT;
        rr.uri    = 8'h00;
        rr.method = meth;
        rr.status = stat;
        rr.last   = 1'b1;

        push.n  = {1'b0, emit} + {1'b0, report};
        push.r0 = emit ? ru : rr;
        push.r1 = rr;
    end

endmodule

FILE: src/hrlp_out_fifo.sv
module hrlp_out_fifo
    import hrlp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  push_t              push,
    input  logic               pop,
    output result_t            head,
    output logic               head_valid,
    output logic [FIFO_CW-1:0] level
);

    result_t            mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_reg, wr_next;
    logic [FIFO_AW-1:0] rd_reg, rd_next;
    logic [FIFO_CW-1:0] cnt_reg, cnt_next;
    logic [FIFO_AW-1:0] wr_plus1;

    assign wr_plus1 = wr_reg + FIFO_AW'(1);

    // Advance pointers and fill level
    always_comb
    begin
        wr_next  = wr_reg + FIFO_AW'(push.n);
        rd_next  = rd_reg + FIFO_AW'(pop);
        cnt_next = cnt_reg + FIFO_CW'(push.n) - FIFO_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Write up to two entries per cycle
    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
            mem_reg[wr_reg] <= push.r0;
        if (push.n == 2'd2)
            mem_reg[wr_plus1] <= push.r1;
    end

    assign head       = mem_reg[rd_reg];
    assign head_valid = (cnt_reg != '0);
    assign level      = cnt_reg;

endmodule

FILE: src/http_request_line_parser.sv
// HTTP request line parser with URI percent decoding.
// Input channel (in_valid/in_ready): one request byte per transfer with
// start_flag on the first byte of a request and final_flag on the last.
// Output channel (out_valid/out_ready): one result per transfer, either a
// decoded URI byte (result_kind 0) or the end-of-line report (result_kind 1)
// with method and status; last_of_run marks the last result of a byte.
// Throughput: one byte per cycle while in_ready is high. A byte that yields
// both a URI byte and the report produces two results, drained one per cycle
// while out_ready is high. Each byte passes the input register, then decode
// into the output queue, before its results reach out_valid.
// The input register feeds an eight-entry output queue; in_ready drops
// when the queue could not take the results of the byte in flight plus
// the next one, so a stalled receiver back-pressures the sender.
// Reset empties the queue and leaves the parser idle until a start byte;
// bytes before a start, or after a line's report, produce nothing.
module http_request_line_parser
    import hrlp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       start_flag,
    input  logic       final_flag,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       result_kind,
    output logic [7:0] uri_byte,
    output logic [1:0] method_code,
    output logic [1:0] status_code,
    output logic       last_of_run
);

    logic               item_valid_reg, item_valid_next;
    logic [7:0]         byte_reg;
    logic               start_reg;
    logic               final_reg;
    push_t              push;
    result_t            head;
    logic               head_valid;
    logic [FIFO_CW-1:0] level;
    logic [FIFO_CW:0]   committed;

    // Reserve room for the byte in flight and the next one
    assign committed = {1'b0, level} + (item_valid_reg ? (FIFO_CW+1)'(2) : '0);
    assign in_ready  = committed <= (FIFO_CW+1)'(FIFO_DEPTH - 2);

    assign item_valid_next = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else
            item_valid_reg <= item_valid_next;
    end

    // Capture the payload on transfer
    always_ff @(posedge clk)
    begin
        if (item_valid_next)
        begin
            byte_reg  <= data_byte;
            start_reg <= start_flag;
            final_reg <= final_flag;
        end
    end

    hrlp_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid_reg),
        .item_byte  (byte_reg),
        .item_start (start_reg),
        .item_final (final_reg),
        .push       (push)
    );

    hrlp_out_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (head_valid && out_ready),
        .head       (head),
        .head_valid (head_valid),
        .level      (level)
    );

    assign out_valid   = head_valid;
    assign result_kind = head.kind;
    assign uri_byte    = head.uri;
    assign method_code = head.method;
    assign status_code = head.status;
    assign last_of_run = head.last;

endmodule

FILE: src/hrlp_checker.sv
module hrlp_checker
    import hrlp_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] data_byte,
    input logic       start_flag,
    input logic       final_flag,
    input logic       out_valid,
    input logic       out_ready,
    input logic       result_kind,
    input logic [7:0] uri_byte,
    input logic [1:0] method_code,
    input logic [1:0] status_code,
    input logic       last_of_run
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(uri_byte)
            && $stable(result_kind) && $stable(status_code))
        else $error("stalled result changed");

    // A report ends its run and carries no URI byte
    a_report_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_REPORT |-> last_of_run && uri_byte == 8'h00
            && method_code != 2'd3 && status_code != 2'd3)
        else $error("malformed report");

    // A URI byte carries zero method and status
    a_uri_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_URI |-> method_code == 2'd0
            && status_code == 2'd0)
        else $error("malformed URI result");

    // Nothing leaves during reset or in the cycle after it
    a_reset_empty: assert property (@(posedge clk)
        $past(!rst_n) |-> !out_valid)
        else $error("result out of reset");

    // A newly risen result needs in_valid to have been seen before it
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) && $past(!out_valid) && $past(!in_valid, 2)
            && $past(!in_valid, 1) && $past(!out_valid, 2) |-> 1'b0)
        else $error("result without input");

endmodule

bind http_request_line_parser hrlp_checker u_hrlp_checker (.*);
